// ----- hdl/dts_pkg.sv -----
// Shared types, character constants and classification helpers for the token scanner.
`timescale 1ns / 1ps

package dts_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Token classes
   localparam logic [3:0] CLS_IDENT  = 4'd0;
   localparam logic [3:0] CLS_INT    = 4'd1;
   localparam logic [3:0] CLS_FLOAT  = 4'd2;
   localparam logic [3:0] CLS_STRING = 4'd3;
   localparam logic [3:0] CLS_ASSIGN = 4'd4;
   localparam logic [3:0] CLS_SEMI   = 4'd5;
   localparam logic [3:0] CLS_LPAREN = 4'd6;
   localparam logic [3:0] CLS_RPAREN = 4'd7;
   localparam logic [3:0] CLS_LBRACK = 4'd8;
   localparam logic [3:0] CLS_RBRACK = 4'd9;
   localparam logic [3:0] CLS_COMMA  = 4'd10;
   localparam logic [3:0] CLS_MINUS  = 4'd11;
   localparam logic [3:0] CLS_EOF    = 4'd12;
   localparam logic [3:0] CLS_NONE   = 4'd0;

   // Error codes
   localparam logic [1:0] ERR_CHAR    = 2'd0;
   localparam logic [1:0] ERR_COMMENT = 2'd1;
   localparam logic [1:0] ERR_STRING  = 2'd2;
   localparam logic [1:0] ERR_DOT     = 2'd3;
   localparam logic [1:0] ERR_NONE    = 2'd0;

   // Characters with special meaning
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_VTAB       = 8'h0B;
   localparam logic [7:0] CH_FEED       = 8'h0C;
   localparam logic [7:0] CH_RETURN     = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_LPAREN     = 8'h28;
   localparam logic [7:0] CH_RPAREN     = 8'h29;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_SEMI       = 8'h3B;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LBRACK     = 8'h5B;
   localparam logic [7:0] CH_RBRACK     = 8'h5D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

   // Most results one source byte can cause
   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] lexeme_byte;
      logic [3:0] token_class;
      logic [1:0] error_code;
   } result_type;

   // All results of one source byte, slot 0 first
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]                   cnt;
   } bundle_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE) ||
             (c == CH_VTAB) || (c == CH_FEED) || (c == CH_RETURN);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
             ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Class of a single-character token, CLS_NONE when not punctuation
   function automatic logic [3:0] punct_class(input logic [7:0] c);
      logic [3:0] pc;
      case (c)
         CH_EQUAL:  pc = CLS_ASSIGN;
         CH_SEMI:   pc = CLS_SEMI;
         CH_LPAREN: pc = CLS_LPAREN;
         CH_RPAREN: pc = CLS_RPAREN;
         CH_LBRACK: pc = CLS_LBRACK;
         CH_RBRACK: pc = CLS_RBRACK;
         CH_COMMA:  pc = CLS_COMMA;
         CH_MINUS:  pc = CLS_MINUS;
         default:   pc = CLS_NONE;
      endcase
      return pc;
   endfunction

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [7:0] b,
                                              input logic [3:0] cls,
                                              input logic [1:0] err);
      result_type r;
      r.kind        = kind;
      r.lexeme_byte = b;
      r.token_class = cls;
      r.error_code  = err;
      return r;
   endfunction

endpackage

// ----- hdl/dsl_token_scanner_core.sv -----
// Top level of the streaming token scanner: front end, bundle queue and back end.
//
// Usage:
//  Source bytes enter on req_ch / req_at_end; a byte is taken at a clock edge
//  with push high and full low. req_at_end, or a zero byte, closes the input.
//  Results leave on the rsp_ ports; the oldest is shown while empty is low and
//  is taken at an edge with pop high. Each result is a lexeme byte, a token
//  end with its class, or an error; rsp_last_of_run marks the final result
//  of one source byte.
//  Throughput: one source byte per cycle as long as the bundle queue has room;
//  results drain at one per cycle while pop is held high, so a byte causing
//  two or three results is absorbed by the queue at the result side.
//  A taken byte's bundle is written into the bundle queue and then loaded into
//  the back end's register, from which its first result is shown and popped.
//  Reset clears the scan mode, the halt flag and the queue. After an error the
//  block keeps taking bytes but produces nothing until reset.
//  When the receiver stalls, the queue fills and full rises; bytes that give
//  no result are still held back until space returns.
`timescale 1ns / 1ps

module dsl_token_scanner_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_ch,
   input  logic       req_at_end,
   input  logic       push,
   output logic       full,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_lexeme_byte,
   output logic [3:0] rsp_token_class,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last_of_run,
   output logic       empty,
   input  logic       pop
);
   import dts_pkg::*;

   logic       accept;
   logic       bundle_write;
   bundle_type bundle;
   bundle_type q_data;
   logic       q_empty;
   logic       q_read;
   result_type result;

   assign accept = push && !full;

   dts_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ch           (req_ch),
      .at_end       (req_at_end),
      .bundle_write (bundle_write),
      .bundle       (bundle)
   );

   dts_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_write),
      .wr_data (bundle),
      .full    (full),
      .rd_en   (q_read),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   dts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .q_read      (q_read),
      .empty       (empty),
      .pop         (pop),
      .result      (result),
      .last_of_run (rsp_last_of_run)
   );

   // Drive result fields
   assign rsp_kind        = result.kind;
   assign rsp_lexeme_byte = result.lexeme_byte;
   assign rsp_token_class = result.token_class;
   assign rsp_error_code  = result.error_code;

endmodule

// ----- hdl/dts_front.sv -----
// Front end: scan mode state machine that classifies each source byte into a result bundle.
`timescale 1ns / 1ps

module dts_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         ch,
   input  logic               at_end,
   output logic               bundle_write,
   output dts_pkg::bundle_type bundle
);
   import dts_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BSTAR,
      MODE_IDENT,
      MODE_INT,
      MODE_FLOAT,
      MODE_STRING
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       halted_ff, halted_in;
   logic [1:0] n;
   logic       do_start;
   logic       source_end;
   logic [3:0] pc;

   assign source_end = at_end || (ch == CH_NUL);
   assign pc         = punct_class(ch);

   // Work out next mode and the results of the accepted byte
   always_comb begin
      mode_in   = mode_ff;
      halted_in = halted_ff;
      bundle    = '0;
      n         = 2'd0;
      do_start  = 1'b0;
      if (accept && !halted_ff) begin
         if (source_end) begin
            case (mode_ff)
               MODE_SLASH: begin
                  bundle.res[n] = make_result(KIND_ERR, 8'd0, CLS_NONE, ERR_CHAR);
                  n = n + 2'd1;
                  halted_in = 1'b1;
                  mode_in = MODE_IDLE;
               end
               MODE_BLOCK, MODE_BSTAR: begin
                  bundle.res[n] = make_result(KIND_ERR, 8'd0, CLS_NONE, ERR_COMMENT);
                  n = n + 2'd1;
                  halted_in = 1'b1;
                  mode_in = MODE_IDLE;
               end
               MODE_STRING: begin
                  bundle.res[n] = make_result(KIND_ERR, 8'd0, CLS_NONE, ERR_STRING);
                  n = n + 2'd1;
                  halted_in = 1'b1;
                  mode_in = MODE_IDLE;
               end
               default: begin
                  // Close an open identifier or number, then the end token
                  if (mode_ff == MODE_IDENT || mode_ff == MODE_INT ||
                      mode_ff == MODE_FLOAT) begin
                     bundle.res[n] = make_result(KIND_END, 8'd0,
                        (mode_ff == MODE_IDENT) ? CLS_IDENT :
                        (mode_ff == MODE_INT) ? CLS_INT : CLS_FLOAT, ERR_NONE);
                     n = n + 2'd1;
                  end
                  bundle.res[n] = make_result(KIND_END, 8'd0, CLS_EOF, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = MODE_IDLE;
               end
            endcase
         end else begin
            case (mode_ff)
               MODE_SLASH: begin
                  if (ch == CH_SLASH) begin
                     mode_in = MODE_LINE;
                  end else if (ch == CH_STAR) begin
                     mode_in = MODE_BLOCK;
                  end else begin
                     bundle.res[n] = make_result(KIND_ERR, 8'd0, CLS_NONE, ERR_CHAR);
                     n = n + 2'd1;
                     halted_in = 1'b1;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_LINE: begin
                  if (ch == CH_NEWLINE) mode_in = MODE_IDLE;
               end
               MODE_BLOCK: begin
                  if (ch == CH_STAR) mode_in = MODE_BSTAR;
               end
               MODE_BSTAR: begin
                  if (ch == CH_SLASH) mode_in = MODE_IDLE;
                  else if (ch != CH_STAR) mode_in = MODE_BLOCK;
               end
               MODE_STRING: begin
                  if (ch == CH_QUOTE) begin
                     bundle.res[n] = make_result(KIND_END, 8'd0, CLS_STRING, ERR_NONE);
                     n = n + 2'd1;
                     mode_in = MODE_IDLE;
                  end else begin
                     bundle.res[n] = make_result(KIND_BYTE, ch, CLS_NONE, ERR_NONE);
                     n = n + 2'd1;
                  end
               end
               MODE_IDENT: begin
                  if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDERSCORE) begin
                     bundle.res[n] = make_result(KIND_BYTE, ch, CLS_NONE, ERR_NONE);
                     n = n + 2'd1;
                  end else begin
                     bundle.res[n] = make_result(KIND_END, 8'd0, CLS_IDENT, ERR_NONE);
                     n = n + 2'd1;
                     do_start = 1'b1;
                  end
               end
               MODE_INT, MODE_FLOAT: begin
                  if (is_digit(ch)) begin
                     bundle.res[n] = make_result(KIND_BYTE, ch, CLS_NONE, ERR_NONE);
                     n = n + 2'd1;
                  end else if (ch == CH_DOT) begin
                     if (mode_ff == MODE_FLOAT) begin
                        bundle.res[n] = make_result(KIND_ERR, 8'd0, CLS_NONE, ERR_DOT);
                        n = n + 2'd1;
                        halted_in = 1'b1;
                        mode_in = MODE_IDLE;
                     end else begin
                        bundle.res[n] = make_result(KIND_BYTE, ch, CLS_NONE, ERR_NONE);
                        n = n + 2'd1;
                        mode_in = MODE_FLOAT;
                     end
                  end else begin
                     bundle.res[n] = make_result(KIND_END, 8'd0,
                        (mode_ff == MODE_FLOAT) ? CLS_FLOAT : CLS_INT, ERR_NONE);
                     n = n + 2'd1;
                     do_start = 1'b1;
                  end
               end
               default: do_start = 1'b1;
            endcase

            // Scan the byte afresh from idle
            if (do_start) begin
               mode_in = MODE_IDLE;
               if (is_space(ch)) begin
                  mode_in = MODE_IDLE;
               end else if (ch == CH_SLASH) begin
                  mode_in = MODE_SLASH;
               end else if (is_alpha(ch) || ch == CH_UNDERSCORE) begin
                  bundle.res[n] = make_result(KIND_BYTE, ch, CLS_NONE, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = MODE_IDENT;
               end else if (is_digit(ch)) begin
                  bundle.res[n] = make_result(KIND_BYTE, ch, CLS_NONE, ERR_NONE);
                  n = n + 2'd1;
                  mode_in = MODE_INT;
               end else if (ch == CH_QUOTE) begin
                  mode_in = MODE_STRING;
               end else if (pc != CLS_NONE) begin
                  bundle.res[n] = make_result(KIND_BYTE, ch, CLS_NONE, ERR_NONE);
                  n = n + 2'd1;
                  bundle.res[n] = make_result(KIND_END, 8'd0, pc, ERR_NONE);
                  n = n + 2'd1;
               end else begin
                  bundle.res[n] = make_result(KIND_ERR, 8'd0, CLS_NONE, ERR_CHAR);
                  n = n + 2'd1;
                  halted_in = 1'b1;
               end
            end
         end
      end
      bundle.cnt   = n;
      bundle_write = accept && (n != 2'd0);
   end

   // Hold scan mode and halt flag
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         halted_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         halted_ff <= halted_in;
      end
   end

   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (mode_ff == MODE_IDLE))
      else $error("scanner halted outside idle mode");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> (halted_ff && !bundle_write))
      else $error("halted scanner resumed or produced results");

endmodule

// ----- hdl/dts_fifo.sv -----
// Bundle queue between the scanning front end and the result back end.
`timescale 1ns / 1ps

module dts_fifo #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  dts_pkg::bundle_type wr_data,
   output logic               full,
   input  logic               rd_en,
   output dts_pkg::bundle_type rd_data,
   output logic               empty
);
   import dts_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type      mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming bundle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && full))
      else $error("bundle queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && empty))
      else $error("bundle queue read while empty");

endmodule

// ----- hdl/dts_back.sv -----
// Back end: unpacks result bundles and presents one result per transaction.
`timescale 1ns / 1ps

module dts_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  dts_pkg::bundle_type q_data,
   output logic                q_read,
   output logic                empty,
   input  logic                pop,
   output dts_pkg::result_type result,
   output logic                last_of_run
);
   import dts_pkg::*;

   bundle_type cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       is_last;
   logic       taken;

   assign is_last     = (idx_ff == (cur_ff.cnt - 2'd1));
   assign taken       = pop && valid_ff;
   assign empty       = !valid_ff;
   assign result      = cur_ff.res[idx_ff];
   assign last_of_run = is_last;

   // Load a new bundle once the current one is drained, else step through slots
   always_comb begin
      q_read   = !q_empty && (!valid_ff || (taken && is_last));
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (q_read) begin
         cur_in   = q_data;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (taken && is_last) begin
         valid_in = 1'b0;
      end else if (taken) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.cnt != 2'd0 && idx_ff < cur_ff.cnt))
      else $error("result slot beyond bundle count");

   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      q_read |=> (valid_ff && idx_ff == 2'd0))
      else $error("loaded bundle does not start at first slot");

endmodule

// ----- bench/tb_dsl_token_scanner_core.sv -----
// Self-checking testbench for the streaming token scanner core.
`timescale 1ns / 1ps

module tb_dsl_token_scanner_core;
   import dts_pkg::*;

   // Scanner modes of the prediction
   typedef enum logic [3:0] {
      SM_IDLE, SM_SLASH, SM_LINE, SM_BLOCK, SM_BSTAR, SM_IDENT, SM_INT, SM_FLOAT, SM_STRING
   } scan_mode_type;

   // Source fragments the stimulus is built from
   typedef enum {
      U_BLANK, U_PUNCT, U_IDENT, U_INT, U_FLOAT, U_STRING, U_LINE, U_BLOCK, U_END
   } unit_type;

   // Ways of ending the run in the halted state
   typedef enum {
      HALT_BAD_CHAR, HALT_SLASH_CHAR, HALT_SLASH_END, HALT_OPEN_BLOCK,
      HALT_OPEN_STAR, HALT_OPEN_STRING, HALT_SECOND_DOT, HALT_AFTER_IDENT
   } halt_case_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] lexeme_byte;
      logic [3:0] token_class;
      logic [1:0] error_code;
      logic       last_of_run;
   } token_result_type;

   // Predict the scanner output per source byte and check the result stream
   class scan_scoreboard;
      scan_mode_type    mode;
      bit               halted;
      token_result_type pending_results[$];
      token_result_type step_results[$];
      int               bytes_taken;
      int               results_checked;
      int               token_ends;
      int               error_results;
      int               failures;

      function new();
         mode = SM_IDLE;
         halted = 1'b0;
         bytes_taken = 0;
         results_checked = 0;
         token_ends = 0;
         error_results = 0;
         failures = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] b, logic [3:0] cls, logic [1:0] err);
         token_result_type r;
         r.kind = kind;
         r.lexeme_byte = b;
         r.token_class = cls;
         r.error_code = err;
         r.last_of_run = 1'b0;
         step_results.push_back(r);
      endfunction

      function void raise_error(logic [1:0] err);
         emit(KIND_ERR, 8'h00, CLS_NONE, err);
         halted = 1'b1;
         mode = SM_IDLE;
      endfunction

      function bit is_blank(logic [7:0] c);
         case (c)
            CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FEED, CH_RETURN: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
      endfunction

      function bit is_numeral(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function logic [3:0] single_char_class(logic [7:0] c);
         case (c)
            CH_EQUAL:  return CLS_ASSIGN;
            CH_SEMI:   return CLS_SEMI;
            CH_LPAREN: return CLS_LPAREN;
            CH_RPAREN: return CLS_RPAREN;
            CH_LBRACK: return CLS_LBRACK;
            CH_RBRACK: return CLS_RBRACK;
            CH_COMMA:  return CLS_COMMA;
            CH_MINUS:  return CLS_MINUS;
            default:   return CLS_NONE;
         endcase
      endfunction

      // Classify a byte with no token open
      function void begin_token(logic [7:0] c);
         logic [3:0] pc;
         pc = single_char_class(c);
         mode = SM_IDLE;
         if (is_blank(c))
            return;
         if (c == CH_SLASH) begin
            mode = SM_SLASH;
         end else if (is_letter(c) || c == CH_UNDERSCORE) begin
            emit(KIND_BYTE, c, CLS_NONE, ERR_NONE);
            mode = SM_IDENT;
         end else if (is_numeral(c)) begin
            emit(KIND_BYTE, c, CLS_NONE, ERR_NONE);
            mode = SM_INT;
         end else if (c == CH_QUOTE) begin
            mode = SM_STRING;
         end else if (pc != CLS_NONE) begin
            emit(KIND_BYTE, c, CLS_NONE, ERR_NONE);
            emit(KIND_END, 8'h00, pc, ERR_NONE);
         end else begin
            raise_error(ERR_CHAR);
         end
      endfunction

      // Close the source: finish an open token, then the end token; error on an open slash, comment or string
      function void close_input();
         case (mode)
            SM_SLASH: begin
               raise_error(ERR_CHAR);
               return;
            end
            SM_BLOCK, SM_BSTAR: begin
               raise_error(ERR_COMMENT);
               return;
            end
            SM_STRING: begin
               raise_error(ERR_STRING);
               return;
            end
            SM_IDENT: emit(KIND_END, 8'h00, CLS_IDENT, ERR_NONE);
            SM_INT:   emit(KIND_END, 8'h00, CLS_INT, ERR_NONE);
            SM_FLOAT: emit(KIND_END, 8'h00, CLS_FLOAT, ERR_NONE);
            default: ;
         endcase
         emit(KIND_END, 8'h00, CLS_EOF, ERR_NONE);
         mode = SM_IDLE;
      endfunction

      function void scan_char(logic [7:0] c);
         case (mode)
            SM_SLASH: begin
               if (c == CH_SLASH) mode = SM_LINE;
               else if (c == CH_STAR) mode = SM_BLOCK;
               else raise_error(ERR_CHAR);
            end
            SM_LINE: begin
               if (c == CH_NEWLINE) mode = SM_IDLE;
            end
            SM_BLOCK: begin
               if (c == CH_STAR) mode = SM_BSTAR;
            end
            SM_BSTAR: begin
               if (c == CH_SLASH) mode = SM_IDLE;
               else if (c != CH_STAR) mode = SM_BLOCK;
            end
            SM_STRING: begin
               if (c == CH_QUOTE) begin
                  emit(KIND_END, 8'h00, CLS_STRING, ERR_NONE);
                  mode = SM_IDLE;
               end else begin
                  emit(KIND_BYTE, c, CLS_NONE, ERR_NONE);
               end
            end
            SM_IDENT: begin
               if (is_letter(c) || is_numeral(c) || c == CH_UNDERSCORE) begin
                  emit(KIND_BYTE, c, CLS_NONE, ERR_NONE);
               end else begin
                  emit(KIND_END, 8'h00, CLS_IDENT, ERR_NONE);
                  begin_token(c);
               end
            end
            SM_INT, SM_FLOAT: begin
               if (is_numeral(c)) begin
                  emit(KIND_BYTE, c, CLS_NONE, ERR_NONE);
               end else if (c == CH_DOT) begin
                  if (mode == SM_FLOAT) begin
                     raise_error(ERR_DOT);
                  end else begin
                     emit(KIND_BYTE, c, CLS_NONE, ERR_NONE);
                     mode = SM_FLOAT;
                  end
               end else begin
                  emit(KIND_END, 8'h00, (mode == SM_FLOAT) ? CLS_FLOAT : CLS_INT, ERR_NONE);
                  begin_token(c);
               end
            end
            default: begin_token(c);
         endcase
      endfunction

      // Note an accepted source byte and queue the results it causes
      function void note_input(logic [7:0] c, logic at_end);
         token_result_type r;
         step_results.delete();
         bytes_taken++;
         if (halted)
            return;
         if (at_end || c == CH_NUL)
            close_input();
         else
            scan_char(c);
         if (step_results.size() > 0) begin
            r = step_results[step_results.size() - 1];
            r.last_of_run = 1'b1;
            step_results[step_results.size() - 1] = r;
         end
         foreach (step_results[i])
            pending_results.push_back(step_results[i]);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      // Check an accepted result against the oldest expectation
      function void check_result(token_result_type got);
         token_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind %0d byte %0d class %0d code %0d",
                   got.kind, got.lexeme_byte, got.token_class, got.error_code);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (want.kind == KIND_END) token_ends++;
         if (want.kind == KIND_ERR) error_results++;
         compare_field("kind", want.kind, got.kind);
         compare_field("lexeme_byte", want.lexeme_byte, got.lexeme_byte);
         compare_field("token_class", want.token_class, got.token_class);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic [7:0] req_ch = 8'h00;
   logic       req_at_end = 1'b0;
   logic       push = 1'b0;
   logic       full;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_lexeme_byte;
   logic [3:0] rsp_token_class;
   logic [1:0] rsp_error_code;
   logic       rsp_last_of_run;
   logic       empty;
   logic       pop = 1'b0;

   scan_scoreboard sb;
   bit             gaps_on = 1'b1;
   bit             long_hold_req = 1'b0;
   int             items_sent = 0;

   dsl_token_scanner_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .req_at_end      (req_at_end),
      .push            (push),
      .full            (full),
      .rsp_kind        (rsp_kind),
      .rsp_lexeme_byte (rsp_lexeme_byte),
      .rsp_token_class (rsp_token_class),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run),
      .empty           (empty),
      .pop             (pop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Watch both channels and feed the scoreboard
   always @(posedge clock) begin : monitor
      token_result_type got;
      if (!reset) begin
         if (push && !full)
            sb.note_input(req_ch, req_at_end);
         if (pop && !empty) begin
            got.kind = rsp_kind;
            got.lexeme_byte = rsp_lexeme_byte;
            got.token_class = rsp_token_class;
            got.error_code = rsp_error_code;
            got.last_of_run = rsp_last_of_run;
            sb.check_result(got);
         end
      end
   end

   // Result side: random pop gaps, plus one long hold-off on request
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            stall_left = 80;
            long_hold_req = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            pop <= !(gaps_on && $urandom_range(99) < 10);
         end
      end
   end

   function automatic logic [7:0] pick_letter();
      if ($urandom_range(1) != 0)
         return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
      return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'($urandom_range(CH_ZERO, CH_NINE));
   endfunction

   function automatic logic [7:0] pick_word_char();
      case ($urandom_range(5))
         0: return CH_UNDERSCORE;
         1, 2: return pick_digit();
         default: return pick_letter();
      endcase
   endfunction

   // Any nonzero byte but the one that would end the current construct
   function automatic logic [7:0] pick_byte_except(logic [7:0] stop);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == stop);
      return b;
   endfunction

   // Offer one source byte and hold it until the transaction completes
   task automatic send_byte(input logic [7:0] c, input logic e);
      if (gaps_on && $urandom_range(99) < 10) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      push <= 1'b1;
      req_ch <= c;
      req_at_end <= e;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], 1'b0);
   endtask

   // Pause the source until every expected result has come out
   task automatic wait_drained();
      push <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Send one well-formed fragment of source text with random content
   task automatic send_unit(input unit_type u);
      logic [7:0] blanks [6];
      logic [7:0] marks [8];
      blanks = '{CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FEED, CH_RETURN};
      marks = '{CH_EQUAL, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_COMMA,
                CH_MINUS};
      case (u)
         U_BLANK: repeat ($urandom_range(1, 3)) send_byte(blanks[$urandom_range(5)], 1'b0);
         U_PUNCT: send_byte(marks[$urandom_range(7)], 1'b0);
         U_IDENT: begin
            send_byte(($urandom_range(5) == 0) ? CH_UNDERSCORE : pick_letter(), 1'b0);
            repeat ($urandom_range(0, 5)) send_byte(pick_word_char(), 1'b0);
         end
         U_INT: repeat ($urandom_range(1, 3)) send_byte(pick_digit(), 1'b0);
         U_FLOAT: begin
            repeat ($urandom_range(1, 2)) send_byte(pick_digit(), 1'b0);
            send_byte(CH_DOT, 1'b0);
            repeat ($urandom_range(0, 2)) send_byte(pick_digit(), 1'b0);
         end
         U_STRING: begin
            send_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 5)) send_byte(pick_byte_except(CH_QUOTE), 1'b0);
            send_byte(CH_QUOTE, 1'b0);
         end
         U_LINE: begin
            send_byte(CH_SLASH, 1'b0);
            send_byte(CH_SLASH, 1'b0);
            repeat ($urandom_range(0, 5)) send_byte(pick_byte_except(CH_NEWLINE), 1'b0);
            // end the comment by newline, or now and then by the end of the source
            if ($urandom_range(4) == 0)
               send_byte(8'($urandom), 1'b1);
            else
               send_byte(CH_NEWLINE, 1'b0);
         end
         U_BLOCK: begin
            send_byte(CH_SLASH, 1'b0);
            send_byte(CH_STAR, 1'b0);
            repeat ($urandom_range(0, 5)) send_byte(pick_byte_except(CH_SLASH), 1'b0);
            repeat ($urandom_range(1, 2)) send_byte(CH_STAR, 1'b0);
            send_byte(CH_SLASH, 1'b0);
         end
         default: begin
            if ($urandom_range(1) != 0)
               send_byte(8'($urandom), 1'b1);
            else
               send_byte(CH_NUL, 1'b0);
         end
      endcase
   endtask

   initial begin : stimulus
      int            random_start;
      int            unit_count;
      int            roll;
      bit            prev_word;
      unit_type      u;
      halt_case_type halt_case;
      logic [7:0]    bad;
      sb = new();
      unit_count = 0;
      prev_word = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: identifier closed by punctuation, float, every mark, string with
      // extreme bytes, block comment with a doubled star, integer closed by end
      send_text("_Z9=0.5;()[],-\"");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_text("\"/**/12");
      send_byte(CH_UPPER_Z, 1'b1);
      wait_drained();

      // Random source text, error free so the scanner never halts early
      random_start = items_sent;
      while (items_sent - random_start < 135) begin
         unit_count++;
         if (unit_count == 8)
            long_hold_req = 1'b1;
         gaps_on = !(unit_count >= 15 && unit_count < 35);
         if (unit_count == 40)
            wait_drained();
         roll = $urandom_range(99);
         if (roll < 15) u = U_BLANK;
         else if (roll < 35) u = U_PUNCT;
         else if (roll < 50) u = U_IDENT;
         else if (roll < 60) u = U_INT;
         else if (roll < 68) u = U_FLOAT;
         else if (roll < 78) u = U_STRING;
         else if (roll < 85) u = U_LINE;
         else if (roll < 92) u = U_BLOCK;
         else u = U_END;
         // keep adjacent words and numbers apart; merged numbers could hit a second dot
         if (prev_word && (u == U_IDENT || u == U_INT || u == U_FLOAT))
            send_unit(($urandom_range(1) != 0) ? U_BLANK : U_PUNCT);
         send_unit(u);
         prev_word = (u == U_IDENT || u == U_INT || u == U_FLOAT);
      end

      // Finish with one error, then feed the halted block
      halt_case = halt_case_type'($urandom_range(7));
      bad = ($urandom_range(1) != 0) ? 8'($urandom_range(128, 255)) : CH_DOT;
      send_byte(CH_SPACE, 1'b0);
      case (halt_case)
         HALT_BAD_CHAR: send_byte(bad, 1'b0);
         HALT_SLASH_CHAR: send_text("/A");
         HALT_SLASH_END: begin
            send_byte(CH_SLASH, 1'b0);
            send_byte(8'($urandom), 1'b1);
         end
         HALT_OPEN_BLOCK: begin
            send_text("/*x");
            send_byte(CH_NUL, 1'b0);
         end
         HALT_OPEN_STAR: begin
            send_text("/**");
            send_byte(8'($urandom), 1'b1);
         end
         HALT_OPEN_STRING: begin
            send_text("\"q");
            send_byte(CH_NUL, 1'b0);
         end
         HALT_SECOND_DOT: send_text("1.2.");
         default: begin
            send_byte(CH_LOWER_A, 1'b0);
            send_byte(bad, 1'b0);
         end
      endcase
      repeat (8) send_byte(8'($urandom), 1'($urandom_range(1)));

      // Drain and let the pipeline settle
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Scanned %0d source bytes into %0d checked results (%0d token ends, %0d errors).",
               sb.bytes_taken, sb.results_checked, sb.token_ends, sb.error_results);
      $display("Run closed with error case %s and bytes fed to the halted scanner.",
               halt_case.name());
      if (sb.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/dts_pkg.sv
hdl/dts_front.sv
hdl/dts_fifo.sv
hdl/dts_back.sv
hdl/dsl_token_scanner_core.sv
bench/tb_dsl_token_scanner_core.sv
